>>> hw/rtl/pcap_stream_deframer_defines.svh
// Assertion macros for the capture stream deframer.
// Included by the top level; no other dependencies.
`ifndef PCAP_STREAM_DEFRAMER_DEFINES_SVH
`define PCAP_STREAM_DEFRAMER_DEFINES_SVH

`ifndef ASSERT_OFF
`define PCAPD_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pcapd assertion failed");
`define PCAPD_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("pcapd assertion failed");
`else
`define PCAPD_ASSERT(name, clk, rst, prop)
`define PCAPD_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

>>> hw/rtl/pcapd_pkg.sv
// Shared types and constants of the capture stream deframer.
// No dependencies.
`default_nettype none

package pcapd_pkg;

   localparam int LEN_WIDTH_DEFAULT = 18;
   localparam int QUEUE_DEPTH       = 4;
   localparam int MAX_LEN_W         = 18;
   localparam int CSR_ADDR_W        = 1;
   localparam int KIND_W            = 2;
   localparam int ERR_W             = 2;
   // data_byte, link_type, ts_seconds, ts_micros and error_code.
   localparam int RSP_FIXED_W       = 8 + 32 + 32 + 32 + ERR_W;

   localparam logic [CSR_ADDR_W-1:0] CSR_REMOVE_CR = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_LEN   = 1'b1;
   localparam logic [MAX_LEN_W-1:0]  MAX_LEN_RESET = 18'd65535;

   localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd3;

   localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
   localparam logic [ERR_W-1:0] ERR_MAGIC    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_MISMATCH = 2'd1;
   localparam logic [ERR_W-1:0] ERR_OVERSIZE = 2'd2;

   localparam logic [7:0]  CH_CR   = 8'h0d;
   localparam logic [7:0]  CH_LF   = 8'h0a;
   localparam logic [31:0] MAGIC_A = 32'hA1B2C3D4;
   localparam logic [31:0] MAGIC_B = 32'hD4C3B2A1;

   // One queued step: an optional released CR followed by an optional byte.
   typedef struct packed {
      logic       pre_cr;
      logic       has_byte;
      logic [7:0] data;
   } entry_type;

endpackage

`default_nettype wire

>>> hw/rtl/pcapd_front.sv
// Front end: accepts raw beats and applies the CR LF filter.
// Depends on pcapd_pkg.
`default_nettype none

module pcapd_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,   // byte_in
   input  wire logic                remove_cr,
   input  wire logic                q_full,
   output logic                     q_push,
   output pcapd_pkg::entry_type     q_entry
);

   logic cr_pending_ff;
   logic cr_pending_in;
   logic accept;
   logic is_cr;
   logic is_lf;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign is_cr      = remove_cr && (req_tdata == pcapd_pkg::CH_CR);
   assign is_lf      = remove_cr && (req_tdata == pcapd_pkg::CH_LF);

   always_comb begin
      q_entry.data     = req_tdata;
      q_entry.pre_cr   = cr_pending_ff && !is_lf;
      q_entry.has_byte = !is_cr || (cr_pending_ff && is_lf);
      cr_pending_in    = cr_pending_ff;
      if (accept) begin
         cr_pending_in = is_cr && !(cr_pending_ff && is_lf);
      end
   end

   assign q_push = accept && (q_entry.pre_cr || q_entry.has_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_pending_ff <= 1'b0;
      end else begin
         cr_pending_ff <= cr_pending_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/pcapd_queue.sv
// Short queue of filtered steps between the front and back ends.
// Depends on pcapd_pkg.
`default_nettype none

module pcapd_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire pcapd_pkg::entry_type push_entry,
   input  wire logic                pop,
   output pcapd_pkg::entry_type     head,
   output logic                     full,
   output logic                     empty
);

   localparam int Depth = pcapd_pkg::QUEUE_DEPTH;
   localparam int PtrW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   pcapd_pkg::entry_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full  = (count_ff == CntW'(Depth));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/pcapd_back.sv
// Back end: header collection, record checks and the result register.
// Depends on pcapd_pkg.
`default_nettype none

module pcapd_back #(
   parameter int LEN_WIDTH = pcapd_pkg::LEN_WIDTH_DEFAULT,
   localparam int RspDataW = ((pcapd_pkg::RSP_FIXED_W + LEN_WIDTH + 7) / 8) * 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [pcapd_pkg::MAX_LEN_W-1:0] max_len,
   input  wire pcapd_pkg::entry_type            head,
   input  wire logic                            empty,
   output logic                                 pop,
   output logic                                 halted,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // data_byte, link_type, ts_seconds, ts_micros, packet_len, error_code, zero fill
   output logic [RspDataW-1:0]                  rsp_tdata,
   output logic [pcapd_pkg::KIND_W-1:0]         rsp_tuser,  // kind
   output logic                                 rsp_tlast   // last_byte
);

   localparam logic [31:0] LenMask = 32'((64'd1 << LEN_WIDTH) - 64'd1);

   typedef enum logic [2:0] {
      PH_GLOBAL = 3'b001,
      PH_RECORD = 3'b010,
      PH_BODY   = 3'b100
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [4:0]             count_ff, count_in;
   logic [31:0]            magic_ff, magic_in;
   logic [31:0]            link_ff, link_in;
   logic [31:0]            ts_sec_ff, ts_sec_in;
   logic [31:0]            ts_usec_ff, ts_usec_in;
   logic [31:0]            cap_len_ff, cap_len_in;
   logic [31:0]            wire_len_ff, wire_len_in;
   logic [LEN_WIDTH-1:0]   left_ff, left_in;
   logic                   halted_ff, halted_in;
   logic                   cr_done_ff, cr_done_in;

   logic                   out_valid_ff, out_valid_in;
   logic [pcapd_pkg::KIND_W-1:0] out_kind_ff, res_kind;
   logic [7:0]             out_data_ff, res_data;
   logic [31:0]            out_link_ff;
   logic [31:0]            out_ts_sec_ff, out_ts_usec_ff;
   logic [LEN_WIDTH-1:0]   out_len_ff;
   logic                   out_last_ff, res_last;
   logic [pcapd_pkg::ERR_W-1:0] out_err_ff, res_err;
   logic                   res_valid;
   logic                   res_rec;

   logic                   can_step;
   logic                   step_valid;
   logic                   do_step;
   logic                   cr_sub;
   logic [7:0]             cur_byte;
   logic [31:0]            limit;
   logic [31:0]            max_len_wide;
   logic [LEN_WIDTH-1:0]   left_dec;

   assign can_step   = !out_valid_ff || rsp_tready;
   assign step_valid = !empty && can_step;
   assign cr_sub     = head.pre_cr && !cr_done_ff;
   assign cur_byte   = cr_sub ? pcapd_pkg::CH_CR : head.data;
   assign pop        = step_valid && !(cr_sub && head.has_byte);
   assign do_step    = step_valid && !halted_ff;
   assign halted     = halted_ff;

   assign max_len_wide = 32'(max_len);
   assign limit        = (max_len_wide < LenMask) ? max_len_wide : LenMask;
   assign left_dec     = left_ff - 1'b1;

   always_comb begin
      cr_done_in = cr_done_ff;
      if (step_valid) begin
         cr_done_in = cr_sub && head.has_byte;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      magic_in    = magic_ff;
      link_in     = link_ff;
      ts_sec_in   = ts_sec_ff;
      ts_usec_in  = ts_usec_ff;
      cap_len_in  = cap_len_ff;
      wire_len_in = wire_len_ff;
      left_in     = left_ff;
      halted_in   = halted_ff;
      res_valid   = 1'b0;
      res_kind    = pcapd_pkg::KIND_HEADER;
      res_data    = 8'd0;
      res_rec     = 1'b0;
      res_last    = 1'b0;
      res_err     = pcapd_pkg::ERR_NONE;
      if (do_step) begin
         case (phase_ff)
            PH_RECORD: begin
               case (count_ff[3:2])
                  2'd0:    ts_sec_in   = {cur_byte, ts_sec_ff[31:8]};
                  2'd1:    ts_usec_in  = {cur_byte, ts_usec_ff[31:8]};
                  2'd2:    cap_len_in  = {cur_byte, cap_len_ff[31:8]};
                  default: wire_len_in = {cur_byte, wire_len_ff[31:8]};
               endcase
               count_in = count_ff + 1'b1;
               if (count_ff == 5'd15) begin
                  count_in = '0;
                  if (cap_len_ff != wire_len_in) begin
                     res_valid = 1'b1;
                     res_kind  = pcapd_pkg::KIND_ERROR;
                     res_err   = pcapd_pkg::ERR_MISMATCH;
                     halted_in = 1'b1;
                  end else if (cap_len_ff > limit) begin
                     res_valid = 1'b1;
                     res_kind  = pcapd_pkg::KIND_ERROR;
                     res_err   = pcapd_pkg::ERR_OVERSIZE;
                     halted_in = 1'b1;
                  end else if (cap_len_ff == '0) begin
                     res_valid = 1'b1;
                     res_kind  = pcapd_pkg::KIND_EMPTY;
                     res_rec   = 1'b1;
                     res_last  = 1'b1;
                  end else begin
                     left_in  = cap_len_ff[LEN_WIDTH-1:0];
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               left_in   = left_dec;
               res_valid = 1'b1;
               res_kind  = pcapd_pkg::KIND_DATA;
               res_data  = cur_byte;
               res_rec   = 1'b1;
               res_last  = (left_dec == '0);
               if (left_dec == '0) begin
                  phase_in = PH_RECORD;
               end
            end
            default: begin
               phase_in = PH_GLOBAL;
               if (count_ff < 5'd4) begin
                  magic_in = {cur_byte, magic_ff[31:8]};
               end else if (count_ff >= 5'd20) begin
                  link_in = {cur_byte, link_ff[31:8]};
               end
               count_in = count_ff + 1'b1;
               if (count_ff == 5'd23) begin
                  count_in  = '0;
                  res_valid = 1'b1;
                  if (magic_ff == pcapd_pkg::MAGIC_A || magic_ff == pcapd_pkg::MAGIC_B) begin
                     phase_in = PH_RECORD;
                     res_kind = pcapd_pkg::KIND_HEADER;
                  end else begin
                     res_kind  = pcapd_pkg::KIND_ERROR;
                     res_err   = pcapd_pkg::ERR_MAGIC;
                     halted_in = 1'b1;
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (can_step) begin
         out_valid_in = do_step && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_GLOBAL;
         count_ff     <= '0;
         magic_ff     <= '0;
         link_ff      <= '0;
         ts_sec_ff    <= '0;
         ts_usec_ff   <= '0;
         cap_len_ff   <= '0;
         wire_len_ff  <= '0;
         left_ff      <= '0;
         halted_ff    <= 1'b0;
         cr_done_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         magic_ff     <= magic_in;
         link_ff      <= link_in;
         ts_sec_ff    <= ts_sec_in;
         ts_usec_ff   <= ts_usec_in;
         cap_len_ff   <= cap_len_in;
         wire_len_ff  <= wire_len_in;
         left_ff      <= left_in;
         halted_ff    <= halted_in;
         cr_done_ff   <= cr_done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_step && do_step && res_valid) begin
         out_kind_ff    <= res_kind;
         out_data_ff    <= res_data;
         out_link_ff    <= link_in;
         out_ts_sec_ff  <= res_rec ? ts_sec_ff : 32'd0;
         out_ts_usec_ff <= res_rec ? ts_usec_ff : 32'd0;
         out_len_ff     <= res_rec ? cap_len_ff[LEN_WIDTH-1:0] : '0;
         out_last_ff    <= res_last;
         out_err_ff     <= res_err;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = RspDataW'({out_err_ff, out_len_ff, out_ts_usec_ff, out_ts_sec_ff,
                                  out_link_ff, out_data_ff});

endmodule

`default_nettype wire

>>> hw/rtl/pcap_stream_deframer.sv
// Capture stream deframer: takes one raw byte a beat, filters CR LF pairs if
// enabled, parses the global and record headers and streams packet bytes. The
// front end accepts one beat every cycle while the four-entry queue has room;
// the back end retires one queued step per cycle while the output register is
// empty or its beat is being accepted, and a CR released with the following
// byte takes a step of its own before that byte. A result beat is held in
// one output register. After an error result all input is drained without
// results until reset. There is no clearing pass after reset.
`default_nettype none

`include "pcap_stream_deframer_defines.svh"

module pcap_stream_deframer #(
   parameter int LEN_WIDTH = pcapd_pkg::LEN_WIDTH_DEFAULT,
   localparam int RspDataW = ((pcapd_pkg::RSP_FIXED_W + LEN_WIDTH + 7) / 8) * 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,   // byte_in
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // data_byte, link_type, ts_seconds, ts_micros, packet_len, error_code, zero fill
   output logic [RspDataW-1:0]                   rsp_tdata,
   output logic [pcapd_pkg::KIND_W-1:0]          rsp_tuser,   // kind
   output logic                                  rsp_tlast,   // last_byte
   input  wire logic                             csr_we,
   input  wire logic [pcapd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [pcapd_pkg::MAX_LEN_W-1:0]  csr_wdata
);

   logic                            remove_cr_ff;
   logic [pcapd_pkg::MAX_LEN_W-1:0] max_len_ff;
   logic                            q_push;
   logic                            q_pop;
   logic                            q_full;
   logic                            q_empty;
   logic                            halted;
   pcapd_pkg::entry_type            q_in;
   pcapd_pkg::entry_type            q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         remove_cr_ff <= 1'b0;
         max_len_ff   <= pcapd_pkg::MAX_LEN_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            pcapd_pkg::CSR_REMOVE_CR: remove_cr_ff <= csr_wdata[0];
            pcapd_pkg::CSR_MAX_LEN:   max_len_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   pcapd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .remove_cr  (remove_cr_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_in)
   );

   pcapd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .head       (q_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   pcapd_back #(
      .LEN_WIDTH (LEN_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .max_len    (max_len_ff),
      .head       (q_head),
      .empty      (q_empty),
      .pop        (q_pop),
      .halted     (halted),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `PCAPD_ASSERT(a_no_push_full, clock, reset, q_push |-> !q_full)
   `PCAPD_ASSERT(a_no_pop_empty, clock, reset, q_pop |-> !q_empty)
   `PCAPD_ASSERT(a_error_halts, clock, reset, (rsp_tvalid && rsp_tready && rsp_tuser == pcapd_pkg::KIND_ERROR) |=> (!rsp_tvalid && halted))
   `PCAPD_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid)

endmodule

`default_nettype wire

>>> tb/pcapd_checker.sv
`timescale 1ns / 100ps
// Result checker for the capture stream deframer: watches the byte, result and register
// ports, predicts every result beat and compares it field by field. Depends on pcapd_pkg.
module pcapd_checker #(
   parameter int LEN_W = pcapd_pkg::LEN_WIDTH_DEFAULT,
   parameter int RSP_W = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [7:0]                       req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [RSP_W-1:0]                 rsp_tdata,
   input  logic [pcapd_pkg::KIND_W-1:0]     rsp_tuser,
   input  logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [pcapd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [pcapd_pkg::MAX_LEN_W-1:0]  csr_wdata,
   output int                               outstanding,
   output int                               fail_count
);
   import pcapd_pkg::*;

   localparam logic [31:0] LEN_MASK = 32'((64'd1 << LEN_W) - 64'd1);
   localparam int OFS_LINK = 8;
   localparam int OFS_SEC  = 40;
   localparam int OFS_USEC = 72;
   localparam int OFS_LEN  = 104;
   localparam int OFS_ERR  = OFS_LEN + LEN_W;

   typedef enum logic [1:0] {
      GLOBAL_HDR  = 2'd0,
      RECORD_HDR  = 2'd1,
      PACKET_BODY = 2'd2
   } parse_stage_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [7:0]        data_byte;
      logic [31:0]       link_type;
      logic [31:0]       ts_seconds;
      logic [31:0]       ts_micros;
      logic [LEN_W-1:0]  packet_len;
      logic              last_byte;
      logic [ERR_W-1:0]  error_code;
   } result_beat_type;

   result_beat_type      expected_beats[$];
   logic                 strip_cr = 1'b0;
   logic [MAX_LEN_W-1:0] max_len = MAX_LEN_RESET;
   logic                 cr_held = 1'b0;
   parse_stage_type      stage = GLOBAL_HDR;
   logic [4:0]           hdr_count = '0;
   logic [31:0]          magic_word = '0;
   logic [31:0]          link_word = '0;
   logic [31:0]          rec_sec = '0;
   logic [31:0]          rec_usec = '0;
   logic [31:0]          cap_len = '0;
   logic [31:0]          wire_len = '0;
   logic [LEN_W-1:0]     bytes_left = '0;
   logic                 halted = 1'b0;
   int                   mismatches = 0;

   initial begin
      outstanding = 0;
      fail_count  = 0;
   end

   task automatic reset_predictor();
      strip_cr   = 1'b0;
      max_len    = MAX_LEN_RESET;
      cr_held    = 1'b0;
      stage      = GLOBAL_HDR;
      hdr_count  = '0;
      magic_word = '0;
      link_word  = '0;
      rec_sec    = '0;
      rec_usec   = '0;
      cap_len    = '0;
      wire_len   = '0;
      bytes_left = '0;
      halted     = 1'b0;
      expected_beats.delete();
   endtask

   task automatic push_beat(input logic [KIND_W-1:0] kind, input logic [7:0] data,
                            input logic rec, input logic last, input logic [ERR_W-1:0] err);
      result_beat_type beat;
      beat.kind       = kind;
      beat.data_byte  = data;
      beat.link_type  = link_word;
      beat.ts_seconds = rec ? rec_sec : 32'd0;
      beat.ts_micros  = rec ? rec_usec : 32'd0;
      beat.packet_len = rec ? cap_len[LEN_W-1:0] : '0;
      beat.last_byte  = last;
      beat.error_code = err;
      expected_beats.push_back(beat);
   endtask

   task automatic raise_error(input logic [ERR_W-1:0] err);
      push_beat(KIND_ERROR, 8'h00, 1'b0, 1'b0, err);
      halted = 1'b1;
   endtask

   task automatic parse_byte(input logic [7:0] b);
      logic [31:0] limit;
      if (!halted) begin
         case (stage)
            RECORD_HDR: begin
               if (hdr_count < 4)
                  rec_sec = {b, rec_sec[31:8]};
               else if (hdr_count < 8)
                  rec_usec = {b, rec_usec[31:8]};
               else if (hdr_count < 12)
                  cap_len = {b, cap_len[31:8]};
               else
                  wire_len = {b, wire_len[31:8]};
               hdr_count++;
               if (hdr_count >= 16) begin
                  hdr_count = '0;
                  limit = ({14'd0, max_len} < LEN_MASK) ? {14'd0, max_len} : LEN_MASK;
                  if (cap_len != wire_len)
                     raise_error(ERR_MISMATCH);
                  else if (cap_len > limit)
                     raise_error(ERR_OVERSIZE);
                  else if (cap_len == 32'd0)
                     push_beat(KIND_EMPTY, 8'h00, 1'b1, 1'b1, ERR_NONE);
                  else begin
                     bytes_left = cap_len[LEN_W-1:0];
                     stage = PACKET_BODY;
                  end
               end
            end
            PACKET_BODY: begin
               bytes_left = bytes_left - 1'b1;
               push_beat(KIND_DATA, b, 1'b1, bytes_left == '0, ERR_NONE);
               if (bytes_left == '0)
                  stage = RECORD_HDR;
            end
            default: begin
               stage = GLOBAL_HDR;
               if (hdr_count < 4)
                  magic_word = {b, magic_word[31:8]};
               else if (hdr_count >= 20)
                  link_word = {b, link_word[31:8]};
               hdr_count++;
               if (hdr_count >= 24) begin
                  hdr_count = '0;
                  if (magic_word == MAGIC_A || magic_word == MAGIC_B) begin
                     stage = RECORD_HDR;
                     push_beat(KIND_HEADER, 8'h00, 1'b0, 1'b0, ERR_NONE);
                  end else begin
                     raise_error(ERR_MAGIC);
                  end
               end
            end
         endcase
      end
   endtask

   // A held CR is either swallowed by a following LF or released ahead of the new byte.
   task automatic filter_byte(input logic [7:0] b);
      logic taken;
      taken = 1'b0;
      if (!halted) begin
         if (cr_held) begin
            cr_held = 1'b0;
            if (strip_cr && b == CH_LF) begin
               parse_byte(CH_LF);
               taken = 1'b1;
            end else begin
               parse_byte(CH_CR);
            end
         end
         if (!taken) begin
            if (strip_cr && b == CH_CR)
               cr_held = 1'b1;
            else
               parse_byte(b);
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   task automatic check_beat();
      result_beat_type want;
      if (expected_beats.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected result beat, expected none, actual kind %0d tdata %h",
                  $time, rsp_tuser, rsp_tdata);
      end else begin
         want = expected_beats.pop_front();
         compare_field("kind", 32'(want.kind), 32'(rsp_tuser));
         compare_field("data_byte", 32'(want.data_byte), 32'(rsp_tdata[7:0]));
         compare_field("link_type", want.link_type, rsp_tdata[OFS_LINK +: 32]);
         compare_field("ts_seconds", want.ts_seconds, rsp_tdata[OFS_SEC +: 32]);
         compare_field("ts_micros", want.ts_micros, rsp_tdata[OFS_USEC +: 32]);
         compare_field("packet_len", 32'(want.packet_len), 32'(rsp_tdata[OFS_LEN +: LEN_W]));
         compare_field("last_byte", 32'(want.last_byte), 32'(rsp_tlast));
         compare_field("error_code", 32'(want.error_code), 32'(rsp_tdata[OFS_ERR +: ERR_W]));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_predictor();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_REMOVE_CR: strip_cr = csr_wdata[0];
               CSR_MAX_LEN:   max_len = csr_wdata;
               default:       ;
            endcase
         end
         if (req_tvalid && req_tready)
            filter_byte(req_tdata);
         if (rsp_tvalid && rsp_tready)
            check_beat();
      end
      outstanding <= expected_beats.size();
      fail_count  <= mismatches;
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Top of the capture stream deframer testbench: clock, reset, byte stimulus and verdict.
// Depends on pcapd_pkg, the pcap_stream_deframer RTL and pcapd_checker.
module testbench;
   import pcapd_pkg::*;

   localparam int          LEN_W        = LEN_WIDTH_DEFAULT;
   localparam int          RSP_W        = ((RSP_FIXED_W + LEN_W + 7) / 8) * 8;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned RANDOM_BYTES = 1450;
   localparam logic [31:0] LEN_MAX      = 32'((64'd1 << LEN_W) - 64'd1);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'h00;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_REMOVE_CR;
   logic [MAX_LEN_W-1:0]  csr_wdata = '0;
   int                    outstanding;
   int                    fail_count;

   int unsigned cycles = 0;
   int unsigned bytes_sent = 0;
   int unsigned req_idle_pct = 8;
   int unsigned rsp_stall_pct = 80;
   int unsigned len_limit = 32'(MAX_LEN_RESET);
   logic        filter_on = 1'b0;
   logic        last_was_cr = 1'b0;

   pcap_stream_deframer #(.LEN_WIDTH(LEN_W)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   pcapd_checker #(.LEN_W(LEN_W), .RSP_W(RSP_W)) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 11))
         0:       return CH_CR;
         1:       return CH_LF;
         2:       return 8'h00;
         3:       return 8'hff;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'h0d0a_0d0a;
         default: return $urandom;
      endcase
   endfunction

   function automatic int unsigned pick_len(input int unsigned limit);
      int unsigned top_len;
      top_len = (limit < 40) ? limit : 40;
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return top_len;
         2:       return (top_len >= 10) ? 10 : top_len;
         3:       return (top_len >= 13) ? 13 : top_len;
         4:       return (limit >= 64) ? $urandom_range(41, 64) : top_len;
         default: return $urandom_range(0, top_len);
      endcase
   endfunction

   function automatic logic [MAX_LEN_W-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return LEN_MAX[MAX_LEN_W-1:0];
         2:       return MAX_LEN_RESET;
         3:       return MAX_LEN_W'($urandom_range(1, 64));
         4:       return MAX_LEN_W'($urandom_range(0, LEN_MAX));
         default: return MAX_LEN_W'($urandom_range(10, 40));
      endcase
   endfunction

   task automatic send_raw(input logic [7:0] value);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      bytes_sent++;
      if (bytes_sent == 600) begin
         req_idle_pct  = 80;
         rsp_stall_pct = 8;
      end else if (bytes_sent == 1200) begin
         req_idle_pct  = 0;
         rsp_stall_pct = 0;
      end
   endtask

   // Sends one byte as the deframer is to see it. With the filter on, an LF may travel
   // as CR LF, and must do so after a CR so that the CR is not swallowed.
   task automatic put_byte(input logic [7:0] value);
      if (filter_on && value == CH_LF && (last_was_cr || $urandom_range(0, 2) == 0))
         send_raw(CH_CR);
      send_raw(value);
      last_was_cr = (value == CH_CR);
   endtask

   task automatic put_word(input logic [31:0] word);
      for (int i = 0; i < 4; i++)
         put_byte(word[8*i +: 8]);
   endtask

   task automatic put_header(input logic [31:0] cap, input logic [31:0] orig);
      put_word(pick_word());
      put_word(pick_word());
      put_word(cap);
      put_word(orig);
   endtask

   task automatic put_packet(input int unsigned len);
      put_header(len, len);
      repeat (len)
         put_byte(pick_byte());
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (16)
         @(posedge clock);
   endtask

   task automatic configure(input logic strip, input logic [MAX_LEN_W-1:0] limit);
      req_tvalid <= 1'b0;
      wait_idle();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_REMOVE_CR;
      csr_wdata <= {{(MAX_LEN_W-1){1'b0}}, strip};
      @(posedge clock);
      csr_addr  <= CSR_MAX_LEN;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we    <= 1'b0;
      filter_on = strip;
      len_limit = 32'(limit);
   endtask

   // The block halts for good after an error, so exactly one error closes the run.
   task automatic finish_with_error();
      int unsigned variant;
      logic [31:0] cap;
      variant = $urandom_range(0, 2);
      case (variant)
         0: begin
            cap = pick_len(len_limit);
            put_header(cap, cap ^ (32'd1 << $urandom_range(0, 31)));
         end
         1: begin
            cap = len_limit + 1;
            put_header(cap, cap);
         end
         default: begin
            if (!filter_on)
               configure(1'b1, len_limit[MAX_LEN_W-1:0]);
            // The header ends on a held CR, so the error comes with the byte after it,
            // which must then be dropped.
            put_header(32'd3, 32'h0d00_0003);
            put_byte(8'h55);
         end
      endcase
   endtask

   initial begin
      repeat (12)
         @(posedge clock);
      reset <= 1'b0;

      put_word($urandom_range(0, 1) ? MAGIC_A : MAGIC_B);
      for (int i = 0; i < 16; i++)
         put_byte((i == 0) ? 8'h00 : (i == 1) ? 8'hff : pick_byte());
      put_word(pick_word());
      put_packet(0);
      put_header(1, 1);
      put_byte(8'hff);
      put_header(3, 3);
      put_byte(8'h00);
      put_byte(CH_CR);
      put_byte(CH_LF);

      configure(1'b1, 18'd13);
      put_header(5, 5);
      put_byte(CH_CR);
      put_byte(CH_LF);
      put_byte(CH_LF);
      put_byte(CH_CR);
      put_byte(CH_CR);
      put_packet(13);
      put_packet(10);
      put_header(2, 2);
      put_byte(8'h41);
      put_byte(CH_CR);

      configure(1'b0, '0);
      put_packet(0);
      put_packet(0);

      configure(1'b1, LEN_MAX[MAX_LEN_W-1:0]);
      put_packet(40);

      while (bytes_sent < RANDOM_BYTES) begin
         configure(1'($urandom_range(0, 1)), pick_limit());
         repeat ($urandom_range(4, 16))
            put_packet(pick_len(len_limit));
      end

      finish_with_error();
      repeat (24)
         send_raw(pick_byte());
      req_tvalid <= 1'b0;
      wait_idle();
      repeat (24)
         @(posedge clock);

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/pcapd_pkg.sv
hw/rtl/pcapd_front.sv
hw/rtl/pcapd_queue.sv
hw/rtl/pcapd_back.sv
hw/rtl/pcap_stream_deframer.sv
tb/pcapd_checker.sv
tb/testbench.sv
